// ===== sv/ddc_pkg.sv =====
// Package for the complex down-converter / FIR decimator.
// Holds state types, register indexes, status structs and helper functions.
// No dependencies.
`default_nettype none

package ddc_pkg;

  // pi in Q2.30 and 1.0 in Q2.30, used to build the oscillator table
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_INC  = 2'd0,
    REG_DECIMATION = 2'd1,
    REG_TAP_COUNT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ROM,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_MOD,
    B_MAC,
    B_DRAIN,
    B_FINISH
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // saturate to 16 bits; returns {clip, value}
  function automatic logic [16:0] sat16(input logic signed [63:0] v);
    logic [16:0] r;
    if (v > 64'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -64'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  // one series step in Q2.30: term * x * x, the divisor is applied by the caller;
  // evaluated at elaboration only
  function automatic longint unsigned series_step(input longint unsigned t,
                                                  input longint unsigned x);
    longint unsigned r;
    r = (t * x) >> 30;
    r = (r * x) >> 30;
    return r;
  endfunction

  // Q2.30 series sum rounded half up to Q1.15 and clamped to [0, 32767]
  function automatic logic [14:0] q15_round(input longint sum);
    longint      q;
    logic [14:0] r;
    q = (sum + 64'sd16384) >>> 15;
    if (q < 0) begin
      q = 0;
    end
    if (q > 32767) begin
      q = 32767;
    end
    r = q[14:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ddc_if.sv =====
// Channel interfaces: sample/coefficient input, result output, config writes.
// Depends on nothing.
`default_nettype none

interface ddc_in_if #(parameter int COEF_BITS = 18);
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic signed [15:0]          sample;
  logic [8:0]                  tap_index;
  logic signed [COEF_BITS-1:0] coef_real;
  logic signed [COEF_BITS-1:0] coef_imag;
  modport source(output valid, req_type, sample, tap_index, coef_real, coef_imag,
                 input ready);
  modport sink(input valid, req_type, sample, tap_index, coef_real, coef_imag,
               output ready);
endinterface

interface ddc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;
  logic               clipped;
  modport source(output valid, out_sample, clipped, input ready);
  modport sink(input valid, out_sample, clipped, output ready);
endinterface

interface ddc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/ddc_fifo.sv =====
// Short word queue between the front (mixer) and the back (filter).
// Depends on ddc_pkg.
`default_nettype none

module ddc_fifo
  import ddc_pkg::*;
#(
  parameter int WIDTH = 84,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output fifo_status_t          status
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign rdata        = mem[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ddc_front.sv =====
// Front end: accepts words, runs the oscillator and mixer, queues results.
// Depends on ddc_pkg, ddc_if.
`default_nettype none

module ddc_front
  import ddc_pkg::*;
#(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COEF_BITS        = 18,
  parameter int WORD_W           = 1 + 9 + 2 * 18 + 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  ddc_in_if.sink                 din,
  input  wire logic [31:0]       phase_inc,
  input  wire back_status_t      bstat,
  input  wire fifo_status_t      fstat,
  output logic                   push,
  output logic      [WORD_W-1:0] word
);
  localparam int AW      = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int QW      = AW - 2;

  front_state_t state, state_next;

  logic [PHASE_BITS-1:0]       phase;
  logic                        is_coef;
  logic signed [15:0]          x;
  logic [8:0]                  tidx;
  logic signed [COEF_BITS-1:0] cre;
  logic signed [COEF_BITS-1:0] cim;
  logic [1:0]                  quad;
  logic [QW-1:0]               raddr;
  logic [14:0]                 s_q;
  logic [14:0]                 c_q;
  logic signed [16:0]          cos_v;
  logic signed [16:0]          sin_v;
  logic signed [32:0]          prod_c;
  logic signed [32:0]          prod_s;
  logic signed [33:0]          rc;
  logic signed [33:0]          rs;
  logic [16:0]                 re_sat;
  logic [16:0]                 im_sat;
  logic                        accept;

  // quarter-wave oscillator table, ten-term series built at elaboration
  logic [14:0] sin_rom [QUARTER];
  logic [14:0] cos_rom [QUARTER];
  for (genvar gi = 0; gi < QUARTER; gi++) begin : g_rom
    localparam longint unsigned XA = PI_Q30 * 64'd2 * 64'(gi) / 64'(SINE_TABLE_DEPTH);
    // sine terms, divisors (k+1)(k+2) for k = 1, 3, ..., 17
    localparam longint unsigned S1 = series_step(XA, XA) / 64'd6;
    localparam longint unsigned S2 = series_step(S1, XA) / 64'd20;
    localparam longint unsigned S3 = series_step(S2, XA) / 64'd42;
    localparam longint unsigned S4 = series_step(S3, XA) / 64'd72;
    localparam longint unsigned S5 = series_step(S4, XA) / 64'd110;
    localparam longint unsigned S6 = series_step(S5, XA) / 64'd156;
    localparam longint unsigned S7 = series_step(S6, XA) / 64'd210;
    localparam longint unsigned S8 = series_step(S7, XA) / 64'd272;
    localparam longint unsigned S9 = series_step(S8, XA) / 64'd342;
    // cosine terms, divisors (k+1)(k+2) for k = 0, 2, ..., 16
    localparam longint unsigned C1 = series_step(ONE_Q30, XA) / 64'd2;
    localparam longint unsigned C2 = series_step(C1, XA) / 64'd12;
    localparam longint unsigned C3 = series_step(C2, XA) / 64'd30;
    localparam longint unsigned C4 = series_step(C3, XA) / 64'd56;
    localparam longint unsigned C5 = series_step(C4, XA) / 64'd90;
    localparam longint unsigned C6 = series_step(C5, XA) / 64'd132;
    localparam longint unsigned C7 = series_step(C6, XA) / 64'd182;
    localparam longint unsigned C8 = series_step(C7, XA) / 64'd240;
    localparam longint unsigned C9 = series_step(C8, XA) / 64'd306;
    localparam longint SSUM = longint'(XA) - longint'(S1) + longint'(S2)
      - longint'(S3) + longint'(S4) - longint'(S5) + longint'(S6)
      - longint'(S7) + longint'(S8) - longint'(S9);
    localparam longint CSUM = longint'(ONE_Q30) - longint'(C1) + longint'(C2)
      - longint'(C3) + longint'(C4) - longint'(C5) + longint'(C6)
      - longint'(C7) + longint'(C8) - longint'(C9);
    assign sin_rom[gi] = q15_round(SSUM);
    assign cos_rom[gi] = q15_round(CSUM);
  end

  assign accept = din.valid && din.ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    din.ready  = (state == F_IDLE) && !bstat.clearing;
    push       = 1'b0;
    case (state)
      F_IDLE: begin
        if (din.valid && !bstat.clearing) begin
          state_next = F_ROM;
        end
      end
      F_ROM:  state_next = F_MUL;
      F_MUL:  state_next = F_PUSH;
      F_PUSH: begin
        if (!fstat.full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // phase accumulator advances on every sample word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept && !din.req_type) begin
      phase <= phase + phase_inc[PHASE_BITS-1:0];
    end
  end

  // capture word, table address from the phase before the step
  always_ff @(posedge clk) begin
    if (accept) begin
      is_coef <= din.req_type;
      x       <= din.sample;
      tidx    <= din.tap_index;
      cre     <= din.coef_real;
      cim     <= din.coef_imag;
      quad    <= phase[PHASE_BITS-1 -: 2];
      raddr   <= phase[PHASE_BITS-3 -: QW];
    end
  end

  // registered table read
  always_ff @(posedge clk) begin
    s_q <= sin_rom[raddr];
    c_q <= cos_rom[raddr];
  end

  // quadrant symmetry
  always_comb begin
    case (quad)
      2'd0: begin
        cos_v = 17'(c_q);
        sin_v = 17'(s_q);
      end
      2'd1: begin
        cos_v = -17'(s_q);
        sin_v = 17'(c_q);
      end
      2'd2: begin
        cos_v = -17'(c_q);
        sin_v = -17'(s_q);
      end
      default: begin
        cos_v = 17'(s_q);
        sin_v = -17'(c_q);
      end
    endcase
  end

  // mixer products
  always_ff @(posedge clk) begin
    prod_c <= x * cos_v;
    prod_s <= x * sin_v;
  end

  // round half up and saturate; the sine branch is negated
  always_comb begin
    rc     = 34'(prod_c) + 34'sd16384;
    rs     = -34'(prod_s) + 34'sd16384;
    re_sat = sat16(64'(rc >>> 15));
    im_sat = sat16(64'(rs >>> 15));
    word   = {is_coef, tidx, cre, cim, re_sat[15:0], im_sat[15:0]};
  end

endmodule

`default_nettype wire

// ===== sv/ddc_back.sv =====
// Back end: history and coefficient memories, decimation count, complex MAC.
// Depends on ddc_pkg, ddc_if.
`default_nettype none

module ddc_back
  import ddc_pkg::*;
#(
  parameter int TAP_CAPACITY = 512,
  parameter int COEF_BITS    = 18,
  parameter int WORD_W       = 1 + 9 + 2 * 18 + 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [WORD_W-1:0] fword,
  input  wire fifo_status_t      fstat,
  output logic                   pop,
  input  wire logic [7:0]        decimation,
  input  wire logic [8:0]        tap_count,
  output back_status_t           bstat,
  ddc_out_if.source              dout
);
  localparam int PW    = $clog2(TAP_CAPACITY);
  localparam int NW    = $clog2(TAP_CAPACITY + 1);
  localparam int PRODW = COEF_BITS + 16;
  localparam int ACC_W = COEF_BITS + 17 + $clog2(TAP_CAPACITY) + 1;

  back_state_t state, state_next;

  // unpacked queue word
  logic                        w_coef;
  logic [8:0]                  w_tidx;
  logic signed [COEF_BITS-1:0] w_cre;
  logic signed [COEF_BITS-1:0] w_cim;
  logic signed [15:0]          w_re;
  logic signed [15:0]          w_im;
  assign {w_coef, w_tidx, w_cre, w_cim, w_re, w_im} = fword;

  logic signed [15:0]          hist_re [TAP_CAPACITY];
  logic signed [15:0]          hist_im [TAP_CAPACITY];
  logic signed [COEF_BITS-1:0] coef_re [TAP_CAPACITY];
  logic signed [COEF_BITS-1:0] coef_im [TAP_CAPACITY];

  logic [PW-1:0]               clr_addr;
  logic [PW-1:0]               pos;
  logic [7:0]                  cnt;
  logic [7:0]                  cnt_inc;
  logic [7:0]                  dec;
  logic                        filter_now;
  logic [NW-1:0]               n_cfg;
  logic [NW-1:0]               nn;
  logic [NW-1:0]               val;
  logic [NW-1:0]               k;
  logic [PW-1:0]               idx;
  logic signed [15:0]          sre;
  logic signed [15:0]          sim;
  logic signed [15:0]          hr_q;
  logic signed [15:0]          hi_q;
  logic signed [COEF_BITS-1:0] cr_q;
  logic signed [COEF_BITS-1:0] ci_q;
  logic signed [PRODW-1:0]     p_re;
  logic signed [PRODW-1:0]     p_im;
  logic                        v1;
  logic                        v2;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W:0]       rnd;
  logic [16:0]                 y_sat;
  logic                        o_valid;
  logic signed [15:0]          o_sample;
  logic                        o_clip;
  logic                        hist_we;
  logic [PW-1:0]               hist_wa;
  logic                        coef_we;
  logic                        in_range;
  logic                        finish_go;

  assign bstat.clearing = (state == B_CLEAR);
  assign dout.valid      = o_valid;
  assign dout.out_sample = o_sample;
  assign dout.clipped    = o_clip;

  // clamp tap count, decimation of zero acts as one
  always_comb begin
    if (tap_count == '0) begin
      n_cfg = NW'(1);
    end else if (int'(tap_count) > TAP_CAPACITY) begin
      n_cfg = NW'(TAP_CAPACITY);
    end else begin
      n_cfg = NW'(tap_count);
    end
    dec        = (decimation == '0) ? 8'd1 : decimation;
    cnt_inc    = cnt + 8'd1;
    filter_now = (cnt_inc >= dec);
    in_range   = (val < nn);
    finish_go  = !o_valid || dout.ready;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      B_CLEAR: begin
        if (clr_addr == PW'(TAP_CAPACITY - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!fstat.empty) begin
          pop        = 1'b1;
          state_next = w_coef ? B_IDLE : B_MOD;
        end
      end
      B_MOD: begin
        if (in_range) begin
          state_next = filter_now ? B_MAC : B_IDLE;
        end
      end
      B_MAC: begin
        if (k == nn - 1'b1) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = B_FINISH;
        end
      end
      B_FINISH: begin
        if (finish_go) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      pos      <= '0;
      cnt      <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      v1 <= (state == B_MAC);
      v2 <= v1;
      if (state == B_MOD && in_range) begin
        pos <= val[PW-1:0];
        cnt <= filter_now ? 8'd0 : cnt_inc;
      end
      if (state == B_FINISH && finish_go) begin
        o_valid <= 1'b1;
      end else if (dout.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // output rounding: twice the Q0 sum
  always_comb begin
    rnd   = (ACC_W + 1)'(acc) + ((ACC_W + 1)'(1) <<< (COEF_BITS - 3));
    y_sat = sat16(64'(rnd >>> (COEF_BITS - 2)));
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      nn  <= n_cfg;
      val <= NW'(pos) + 1'b1;
      sre <= w_re;
      sim <= w_im;
    end
    // position modulo tap count, one subtract per cycle
    if (state == B_MOD) begin
      if (!in_range) begin
        val <= val - nn;
      end else begin
        k   <= '0;
        idx <= val[PW-1:0];
        acc <= '0;
      end
    end
    if (state == B_MAC) begin
      k   <= k + 1'b1;
      idx <= (idx == '0) ? PW'(nn - 1'b1) : idx - 1'b1;
    end
    p_re <= cr_q * hr_q;
    p_im <= ci_q * hi_q;
    if (v2) begin
      acc <= acc + ACC_W'(p_re) - ACC_W'(p_im);
    end
    if (state == B_FINISH && finish_go) begin
      o_sample <= y_sat[15:0];
      o_clip   <= y_sat[16];
    end
  end

  // history memory: clearing sweep or new mixed word
  assign hist_we = (state == B_CLEAR) || (state == B_MOD && in_range);
  assign hist_wa = (state == B_CLEAR) ? clr_addr : val[PW-1:0];

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_re[hist_wa] <= (state == B_CLEAR) ? 16'sd0 : sre;
      hist_im[hist_wa] <= (state == B_CLEAR) ? 16'sd0 : sim;
    end
    hr_q <= hist_re[idx];
    hi_q <= hist_im[idx];
  end

  // coefficient memory; slots beyond capacity are dropped
  assign coef_we = pop && w_coef && (int'(w_tidx) < TAP_CAPACITY);

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_re[PW'(w_tidx)] <= w_cre;
      coef_im[PW'(w_tidx)] <= w_cim;
    end
    cr_q <= coef_re[k[PW-1:0]];
    ci_q <= coef_im[k[PW-1:0]];
  end

endmodule

`default_nettype wire

// ===== sv/complex_downconvert_fir_decimator.sv =====
// Complex down-converter with FIR decimator. Front: per word, accept, table
// read, mixer multiply and queue push (waits while the queue is full). Back:
// coefficient word stored on pop; sample word wrapped to the tap count by
// subtract steps, and on a decimation-th sample the n-tap MAC, read/multiply
// drain and output step. Reset: synchronous; afterwards a sweep zeroes the
// history while no word is accepted. Config writes are taken at any time.
`default_nettype none

module complex_downconvert_fir_decimator
  import ddc_pkg::*;
#(
  parameter int TAP_CAPACITY     = 512,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COEF_BITS        = 18,
  parameter int PHASE_BITS       = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  ddc_cfg_if.sink   cfg,
  ddc_in_if.sink    din,
  ddc_out_if.source dout
);
  localparam int WORD_W = 1 + 9 + 2 * COEF_BITS + 32;

  logic [31:0]       phase_inc;
  logic [7:0]        decimation;
  logic [8:0]        tap_count;
  logic              push;
  logic              pop;
  logic [WORD_W-1:0] qin;
  logic [WORD_W-1:0] qout;
  fifo_status_t      fstat;
  back_status_t      bstat;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc  <= 32'd0;
      decimation <= 8'd4;
      tap_count  <= 9'd65;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_PHASE_INC:  phase_inc  <= cfg.data;
        REG_DECIMATION: decimation <= cfg.data[7:0];
        REG_TAP_COUNT:  tap_count  <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

  ddc_front #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .COEF_BITS       (COEF_BITS),
    .WORD_W          (WORD_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .phase_inc(phase_inc),
    .bstat    (bstat),
    .fstat    (fstat),
    .push     (push),
    .word     (qin)
  );

  ddc_fifo #(
    .WIDTH(WORD_W),
    .DEPTH(2)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (qin),
    .pop   (pop),
    .rdata (qout),
    .status(fstat)
  );

  ddc_back #(
    .TAP_CAPACITY(TAP_CAPACITY),
    .COEF_BITS   (COEF_BITS),
    .WORD_W      (WORD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fword     (qout),
    .fstat     (fstat),
    .pop       (pop),
    .decimation(decimation),
    .tap_count (tap_count),
    .bstat     (bstat),
    .dout      (dout)
  );

endmodule

`default_nettype wire

// ===== sv/ddc_checker.sv =====
// Port-level checks for the down-converter, bound to the top level.
// Depends on the top level's interface ports.
`default_nettype none

module ddc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        o_valid,
  input wire logic        o_ready,
  input wire logic [15:0] o_sample,
  input wire logic        o_clip
);

  // a pending result word is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(o_sample) && $stable(o_clip))
    else $error("output word dropped or changed while stalled");

  // clipped words sit at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_clip |-> (o_sample == 16'h7fff || o_sample == 16'h8000))
    else $error("clipped set on unsaturated value");

  // an unclipped word at the positive rail carries no clip flag
  a_rail_clip: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_clip && o_sample == 16'h7fff |-> !o_clip)
    else $error("clip flag mismatch");

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !o_valid)
    else $error("output valid after reset");

endmodule

bind complex_downconvert_fir_decimator ddc_checker u_ddc_checker (
  .clk     (clk),
  .rst     (rst),
  .o_valid (dout.valid),
  .o_ready (dout.ready),
  .o_sample(dout.out_sample),
  .o_clip  (dout.clipped)
);

`default_nettype wire

// ===== test/ddc_tb_pkg.sv =====
// Testbench-side word type for the down-converter bench.
// Depends on nothing; used by the top-level bench in tb.sv.
`timescale 1ns / 1ps

package ddc_tb_pkg;

  // one input word as the sender drives it
  typedef struct packed {
    logic               req_type;
    logic signed [15:0] sample;
    logic [8:0]         tap_index;
    logic signed [17:0] coef_real;
    logic signed [17:0] coef_imag;
  } ddc_word_t;

  // one output word as the block should deliver it
  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               clipped;
  } ddc_result_t;

endpackage

// ===== test/tb.sv =====
// Self-checking bench for complex_downconvert_fir_decimator: a mixer/FIR
// predictor in a scoreboard class, random traffic with gaps and back-pressure.
// Depends on ddc_pkg, ddc_if.sv and ddc_tb_pkg.
`timescale 1ns / 1ps

module tb;
  import ddc_pkg::*;
  import ddc_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1100;
  localparam int COEF_FILL      = 128;

  // predictor of the mixer, history and decimating filter
  class DdcScoreboard;
    int          cos_lut[1024];
    int          sin_lut[1024];
    logic [31:0] phase_step;
    logic [7:0]  decim;
    logic [8:0]  taps;
    logic [31:0] phase;
    int          hist_re[512];
    int          hist_im[512];
    int          pos;
    logic [7:0]  decim_cnt;
    int          cre[512];
    int          cim[512];
    ddc_result_t expected_q[$];
    int          errors;
    int          results;
    int          samples;
    int          clips;

    function new();
      build_lut();
      phase_step = 0;
      decim      = 8'd4;
      taps       = 9'd65;
      phase      = 0;
      pos        = 0;
      decim_cnt  = 0;
      errors     = 0;
      results    = 0;
      samples    = 0;
      clips      = 0;
      foreach (hist_re[i]) begin
        hist_re[i] = 0;
        hist_im[i] = 0;
        cre[i]     = 0;
        cim[i]     = 0;
      end
    endfunction

    // round half up: floor((v + 2^(s-1)) / 2^s)
    function longint rnd(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Taylor series in Q2.30, first quadrant only
    function int quad_value(longint unsigned x, bit odd);
      longint unsigned term;
      longint unsigned k;
      longint          acc;
      longint          q;
      term = odd ? x : 64'd1073741824;
      acc  = longint'(term);
      k    = odd ? 1 : 0;
      for (int n = 1; n <= 9; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((k + 1) * (k + 2));
        k    = k + 2;
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      q = rnd(acc, 15);
      if (q < 0) q = 0;
      if (q > 32767) q = 32767;
      return int'(q);
    endfunction

    function void build_lut();
      longint unsigned x;
      int s;
      int c;
      for (int i = 0; i < 1024; i++) begin
        x = 64'd3373259426 * 2 * longint'(i % 256) / 1024;
        s = quad_value(x, 1);
        c = quad_value(x, 0);
        case (i / 256)
          0: begin cos_lut[i] = c;  sin_lut[i] = s;  end
          1: begin cos_lut[i] = -s; sin_lut[i] = c;  end
          2: begin cos_lut[i] = -c; sin_lut[i] = -s; end
          default: begin cos_lut[i] = s; sin_lut[i] = -c; end
        endcase
      end
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_PHASE_INC:  phase_step = data;
        REG_DECIMATION: decim = data[7:0];
        REG_TAP_COUNT:  taps = data[8:0];
        default: ;
      endcase
    endfunction

    // account for one accepted input word
    function void note_input(ddc_word_t w);
      int     n;
      int     dec;
      int     idx;
      longint x;
      longint acc;
      longint y;
      ddc_result_t r;
      if (w.req_type) begin
        cre[w.tap_index] = w.coef_real;
        cim[w.tap_index] = w.coef_imag;
        return;
      end
      samples++;
      n = (taps == 0) ? 1 : int'(taps);
      x = w.sample;
      hist_idx_update(n, clamp16(rnd(x * cos_lut[phase[31:22]], 15)),
                      clamp16(rnd(-(x * sin_lut[phase[31:22]]), 15)));
      phase = phase + phase_step;
      dec = (decim == 0) ? 1 : int'(decim);
      decim_cnt = decim_cnt + 8'd1;
      if (int'(decim_cnt) < dec) return;
      decim_cnt = 0;
      acc = 0;
      idx = pos;
      for (int k = 0; k < n; k++) begin
        acc += longint'(cre[k]) * hist_re[idx] - longint'(cim[k]) * hist_im[idx];
        idx = (idx == 0) ? n - 1 : idx - 1;
      end
      y = rnd(acc, 16);
      r.clipped = (y > 32767 || y < -32768);
      r.out_sample = clamp16(y);
      expected_q.push_back(r);
    endfunction

    function void hist_idx_update(int n, longint re, longint im);
      pos = (pos + 1) % n;
      hist_re[pos] = int'(re);
      hist_im[pos] = int'(im);
    endfunction

    // compare one delivered word with the oldest expectation
    function void check_result(logic signed [15:0] y, logic clip);
      ddc_result_t e;
      results++;
      if (expected_q.size() == 0) begin
        $error("unexpected output word: out_sample=%0d clipped=%0b", y, clip);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (clip) clips++;
      if (y !== e.out_sample) begin
        $error("out_sample mismatch: expected %0d, actual %0d", e.out_sample, y);
        errors++;
      end
      if (clip !== e.clipped) begin
        $error("clipped mismatch: expected %0b, actual %0b", e.clipped, clip);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ddc_cfg_if        cfg_ch ();
  ddc_in_if #(18)   din_ch ();
  ddc_out_if        dout_ch ();

  complex_downconvert_fir_decimator uut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .din  (din_ch),
    .dout (dout_ch)
  );

  DdcScoreboard sb;
  logic         hold_out;
  logic         no_gaps;
  int           idle_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // watchdog: cycles with no word accepted on any channel
  always @(posedge clk) begin
    if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    int gap;
    int held;
    held = 0;
    forever begin
      gap = pick_gap();
      if (hold_out && held == 0) begin
        gap  = 1500;
        held = 1;
      end
      if (gap > 0) begin
        dout_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      dout_ch.ready <= 1'b1;
      @(posedge clk);
      if (dout_ch.valid && dout_ch.ready) sb.check_result(dout_ch.out_sample, dout_ch.clipped);
    end
  end

  task automatic write_cfg(cfg_reg_t idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(ddc_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid     <= 1'b1;
    din_ch.req_type  <= w.req_type;
    din_ch.sample    <= w.sample;
    din_ch.tap_index <= w.tap_index;
    din_ch.coef_real <= w.coef_real;
    din_ch.coef_imag <= w.coef_imag;
    do @(posedge clk); while (!din_ch.ready);
    sb.note_input(w);
  endtask

  task automatic send_sample(logic signed [15:0] s);
    ddc_word_t w;
    w.req_type  = 1'b0;
    w.sample    = s;
    w.tap_index = 9'($urandom);
    w.coef_real = 18'($urandom);
    w.coef_imag = 18'($urandom);
    send_word(w);
  endtask

  task automatic send_coef(logic [8:0] slot, logic signed [17:0] cr, logic signed [17:0] ci);
    ddc_word_t w;
    w.req_type  = 1'b1;
    w.sample    = 16'($urandom);
    w.tap_index = slot;
    w.coef_real = cr;
    w.coef_imag = ci;
    send_word(w);
  endtask

  // stop offering, let every expected word arrive, then let the block settle
  task automatic drain();
    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic setup(logic [31:0] inc, logic [31:0] dec, logic [31:0] ntap);
    drain();
    write_cfg(REG_PHASE_INC, inc);
    write_cfg(REG_DECIMATION, dec);
    write_cfg(REG_TAP_COUNT, ntap);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 7)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15)
        send_coef(9'($urandom), 18'($urandom), 18'($urandom));
      else
        send_sample(rand_sample());
    end
  endtask

  initial begin
    sb = new();
    hold_out      = 1'b0;
    no_gaps       = 1'b0;
    idle_cycles   = 0;
    rst           = 1'b1;
    clk           = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_PHASE_INC;
    cfg_ch.data   = '0;
    din_ch.valid  = 1'b0;
    din_ch.req_type  = 1'b0;
    din_ch.sample    = '0;
    din_ch.tap_index = '0;
    din_ch.coef_real = '0;
    din_ch.coef_imag = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // fill the low coefficient slots, enough for the largest tap count used
    no_gaps = 1'b1;
    send_coef(9'd0, 18'sh1ffff, 18'sh1ffff);
    send_coef(9'd1, -18'sh20000, -18'sh20000);
    for (int s = 2; s < COEF_FILL; s++) send_coef(9'(s), 18'($urandom), 18'($urandom));
    no_gaps = 1'b0;

    // directed, reset settings: extremes, coefficient update mid-stream
    for (int i = 0; i < 6; i++) send_sample(16'sh7fff);
    for (int i = 0; i < 4; i++) send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_coef(9'd2, 18'sh1ffff, -18'sh20000);
    send_sample(-16'sd1);
    send_sample(16'sh7fff);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);

    // zero tap count acts as one, zero decimation as one
    setup(32'h7fffffff, 32'd0, 32'd0);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7fff);

    // decimation lowered below the running count
    setup(32'h40000000, 32'd8, 32'd3);
    for (int i = 0; i < 3; i++) send_sample(rand_sample());
    drain();
    write_cfg(REG_DECIMATION, 32'd2);
    for (int i = 0; i < 3; i++) send_sample(rand_sample());

    // random phase steps but one of half a turn; a long output hold-off in the first one
    setup($urandom, 32'd1, 32'd16);
    hold_out = 1'b1;
    random_run(120);
    setup($urandom, 32'hffffff03, 32'hfffffe07);
    random_run(100);
    setup(32'h80000000, 32'd9, 32'd128);
    random_run(112);
    setup($urandom, 32'd5, 32'd40);
    random_run(60);

    drain();
    $display("Run covered %0d samples, %0d output words (%0d clipped), register extremes",
             sb.samples, sb.results, sb.clips);
    $display("including zero taps/decimation, 128 taps, a long output stall and gaps.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ddc_pkg.sv
sv/ddc_if.sv
sv/ddc_fifo.sv
sv/ddc_front.sv
sv/ddc_back.sv
sv/complex_downconvert_fir_decimator.sv
sv/ddc_checker.sv
test/ddc_tb_pkg.sv
test/tb.sv
